### rtl/core/kmgq_pkg.sv
package kmgq_pkg;
	localparam int NUM_CENTROIDS = 14;
	localparam int CW = 4;
	localparam logic [15:0] COS45_Q15 = 16'd23170;

	typedef logic signed [15:0] coord_t;

	// Seed code per centroid and axis: 2=+r, 1=+h, 0=0, -1=-h, -2=-r.
	typedef logic signed [2:0] seed_code_t;

	function automatic seed_code_t seed_code(input logic [CW-1:0] j, input logic [1:0] a);
		seed_code_t t [0:13][0:2];
		t[0]  = '{3'sd2, 3'sd0, 3'sd0};
		t[1]  = '{3'sd1, 3'sd0, 3'sd1};
		t[2]  = '{3'sd0, 3'sd0, 3'sd2};
		t[3]  = '{-3'sd1, 3'sd0, 3'sd1};
		t[4]  = '{-3'sd2, 3'sd0, 3'sd0};
		t[5]  = '{-3'sd1, 3'sd0, -3'sd1};
		t[6]  = '{3'sd0, 3'sd0, -3'sd2};
		t[7]  = '{3'sd1, 3'sd0, -3'sd1};
		t[8]  = '{3'sd0, 3'sd2, 3'sd0};
		t[9]  = '{3'sd0, 3'sd1, 3'sd1};
		t[10] = '{3'sd0, -3'sd1, 3'sd1};
		t[11] = '{3'sd0, -3'sd2, 3'sd0};
		t[12] = '{3'sd0, -3'sd1, -3'sd1};
		t[13] = '{3'sd0, 3'sd1, -3'sd1};
		if (j > 4'd13 || a > 2'd2) return 3'sd0;
		return t[j][a];
	endfunction
endpackage

### rtl/core/kmgq_if.sv
interface kmgq_in_if;
	logic valid;
	logic ready;
	logic signed [15:0] accel_x;
	logic signed [15:0] accel_y;
	logic signed [15:0] accel_z;
	logic final_sample;
	modport source(output valid, accel_x, accel_y, accel_z, final_sample, input ready);
	modport sink(input valid, accel_x, accel_y, accel_z, final_sample, output ready);
endinterface

interface kmgq_out_if;
	logic valid;
	logic ready;
	logic [5:0] sample_index;
	logic [3:0] cluster_id;
	logic overflowed;
	logic last_result;
	modport source(output valid, sample_index, cluster_id, overflowed, last_result, input ready);
	modport sink(input valid, sample_index, cluster_id, overflowed, last_result, output ready);
endinterface

### rtl/core/kmgq_ram.sv
module kmgq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### rtl/core/kmgq_divider.sv
module kmgq_divider (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [21:0] dividend,
	input  logic [6:0]  divisor,
	output logic        done,
	output logic [21:0] quotient
);
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic [21:0] num_q;
	logic [7:0]  rem_q;
	logic [7:0]  trial;

	assign trial = {rem_q[6:0], num_q[21]};
	assign quotient = num_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 5'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd21) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			if (trial >= {1'b0, divisor}) begin
				rem_q <= trial - {1'b0, divisor};
				num_q <= {num_q[20:0], 1'b1};
			end else begin
				rem_q <= trial;
				num_q <= {num_q[20:0], 1'b0};
			end
		end
	end
endmodule

### rtl/core/kmeans_gesture_quantizer.sv
// During loading, samples that are not final are taken back to back.
// Clustering runs after the final sample: each pass assigns every sample to its nearest
// centroid, accumulates the per-centroid sums and then computes the means by up to 42
// serial divisions (an empty centroid is skipped), up to max_iterations passes.
// Results then stream in sample order, each held until taken. arst_n clears control state,
// the sample count and the overflow flag, and sets the registers to their reset values.
module kmeans_gesture_quantizer #(
	parameter int MAX_SAMPLES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	kmgq_in_if.sink     in_ch,
	kmgq_out_if.source  out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:2]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import kmgq_pkg::*;

	localparam int AW = $clog2(MAX_SAMPLES);
	localparam int NW = $clog2(MAX_SAMPLES + 1);

	typedef enum logic [4:0] {
		S_LOAD, S_SEED, S_A_RD, S_A_WAIT, S_A_DIST, S_A_MUL, S_A_ACC, S_A_CMP,
		S_A_WR, S_CLR, S_U_RD, S_U_WAIT, S_U_ACC, S_M_START, S_M_WAIT, S_M_NEXT,
		S_CHECK, S_O_RD, S_O_WAIT, S_O_SHOW
	} state_t;

	state_t state_q;
	logic [14:0] radius_q;
	logic [6:0]  maxit_q;
	logic [NW-1:0] n_q;
	logic        ovf_q;
	logic [AW-1:0] i_q;
	logic [CW-1:0] j_q;
	logic [1:0]  a_q;
	logic [6:0]  iter_q;
	logic        changed_q;
	logic [34:0] d_q;
	logic [34:0] best_q;
	logic [CW-1:0] bidx_q;
	logic signed [16:0] diff_q;
	logic [33:0] sq_q;
	logic [15:0] h_q;
	logic [31:0] hprod;

	coord_t cen_q [NUM_CENTROIDS][3];
	logic signed [21:0] sum_q [NUM_CENTROIDS][3];
	logic [6:0] cnt_q [NUM_CENTROIDS];

	logic        s_we;
	logic [AW-1:0] s_waddr, s_raddr;
	logic [47:0] s_wdata, s_rdata;
	logic        a_we;
	logic [3:0]  a_wdata, a_rdata;
	logic [AW-1:0] a_raddr;

	logic        div_start, div_done;
	logic [21:0] div_num, div_q;
	logic signed [21:0] cur_sum;
	logic        cur_neg;

	kmgq_ram #(.WIDTH(48), .DEPTH(MAX_SAMPLES)) u_samples (
		.clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
		.raddr(s_raddr), .rdata(s_rdata)
	);
	kmgq_ram #(.WIDTH(4), .DEPTH(MAX_SAMPLES)) u_assign (
		.clk(clk), .we(a_we), .waddr(i_q), .wdata(a_wdata),
		.raddr(a_raddr), .rdata(a_rdata)
	);
	kmgq_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_num),
		.divisor(cnt_q[j_q]), .done(div_done), .quotient(div_q)
	);

	assign in_ch.ready = (state_q == S_LOAD);
	assign s_we = in_ch.valid && in_ch.ready && (n_q < NW'(MAX_SAMPLES));
	assign s_waddr = n_q[AW-1:0];
	assign s_wdata = {in_ch.accel_z, in_ch.accel_y, in_ch.accel_x};
	assign s_raddr = i_q;
	assign a_raddr = i_q;
	assign a_we = (state_q == S_A_WR);
	assign a_wdata = bidx_q;
	assign hprod = 32'(radius_q) * 32'(COS45_Q15) + 32'd16384;

	assign cur_sum = sum_q[j_q][a_q];
	assign cur_neg = cur_sum[21];
	assign div_num = (cur_neg ? 22'(-cur_sum) : 22'(cur_sum)) + 22'(cnt_q[j_q][6:1]);
	assign div_start = (state_q == S_M_START);

	assign pready = 1'b1;
	assign prdata = paddr[2] ? {25'd0, maxit_q} : {17'd0, radius_q};

	assign out_ch.valid = (state_q == S_O_SHOW);
	assign out_ch.sample_index = 6'(i_q);
	assign out_ch.cluster_id = a_rdata;
	assign out_ch.overflowed = ovf_q;
	assign out_ch.last_result = (NW'(i_q) + NW'(1) == n_q);

	function automatic coord_t seed_val(input seed_code_t c, input logic [14:0] r,
		input logic [15:0] h);
		case (c)
			3'sd2:   return coord_t'({1'b0, r});
			3'sd1:   return coord_t'(h);
			-3'sd1:  return -coord_t'(h);
			-3'sd2:  return -coord_t'({1'b0, r});
			default: return '0;
		endcase
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= 15'd256;
			maxit_q <= 7'd100;
		end else if (psel && penable && pwrite) begin
			if (paddr[2]) maxit_q <= pwdata[6:0];
			else radius_q <= pwdata[14:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			n_q <= '0;
			ovf_q <= 1'b0;
			i_q <= '0;
			j_q <= '0;
			a_q <= '0;
			iter_q <= '0;
			changed_q <= 1'b0;
		end else begin
			case (state_q)
				S_LOAD: begin
					if (in_ch.valid) begin
						if (n_q < NW'(MAX_SAMPLES)) n_q <= n_q + NW'(1);
						else ovf_q <= 1'b1;
						if (in_ch.final_sample) begin
							state_q <= S_SEED;
							h_q <= hprod[30:15];
							iter_q <= '0;
						end
					end
				end
				S_SEED: begin
					for (int j = 0; j < NUM_CENTROIDS; j++)
						for (int a = 0; a < 3; a++)
							cen_q[j][a] <= seed_val(seed_code(4'(j), 2'(a)), radius_q, h_q);
					changed_q <= 1'b1;
					i_q <= '0;
					state_q <= S_A_RD;
				end
				S_A_RD: begin
					j_q <= '0;
					a_q <= '0;
					d_q <= '0;
					state_q <= S_A_WAIT;
				end
				S_A_WAIT: state_q <= S_A_DIST;
				S_A_DIST: begin
					diff_q <= 17'(signed'(s_rdata[16*a_q +: 16])) - 17'(cen_q[j_q][a_q]);
					state_q <= S_A_MUL;
				end
				S_A_MUL: begin
					sq_q <= 34'(diff_q * diff_q);
					state_q <= S_A_ACC;
				end
				S_A_ACC: begin
					if (a_q == 2'd2) begin
						d_q <= d_q + 35'(sq_q);
						state_q <= S_A_CMP;
					end else begin
						d_q <= d_q + 35'(sq_q);
						a_q <= a_q + 2'd1;
						state_q <= S_A_DIST;
					end
				end
				S_A_CMP: begin
					if (j_q == '0 || d_q < best_q) begin
						best_q <= d_q;
						bidx_q <= j_q;
					end
					d_q <= '0;
					a_q <= '0;
					if (j_q == CW'(NUM_CENTROIDS - 1)) state_q <= S_A_WR;
					else begin
						j_q <= j_q + CW'(1);
						state_q <= S_A_DIST;
					end
				end
				S_A_WR: begin
					if (bidx_q != a_rdata) changed_q <= 1'b1;
					if (NW'(i_q) + NW'(1) == n_q) begin
						i_q <= '0;
						state_q <= S_CLR;
					end else begin
						i_q <= i_q + AW'(1);
						state_q <= S_A_RD;
					end
				end
				S_CLR: begin
					for (int j = 0; j < NUM_CENTROIDS; j++) begin
						cnt_q[j] <= '0;
						for (int a = 0; a < 3; a++) sum_q[j][a] <= '0;
					end
					state_q <= S_U_RD;
				end
				S_U_RD: state_q <= S_U_WAIT;
				S_U_WAIT: state_q <= S_U_ACC;
				S_U_ACC: begin
					if (a_rdata < 4'(NUM_CENTROIDS)) begin
						for (int a = 0; a < 3; a++)
							sum_q[a_rdata][a] <= sum_q[a_rdata][a]
								+ 22'(signed'(s_rdata[16*a +: 16]));
						cnt_q[a_rdata] <= cnt_q[a_rdata] + 7'd1;
					end
					if (NW'(i_q) + NW'(1) == n_q) begin
						j_q <= '0;
						a_q <= '0;
						state_q <= S_M_START;
					end else begin
						i_q <= i_q + AW'(1);
						state_q <= S_U_RD;
					end
				end
				S_M_START: begin
					if (cnt_q[j_q] == '0) state_q <= S_M_NEXT;
					else state_q <= S_M_WAIT;
				end
				S_M_WAIT: begin
					if (div_done) begin
						cen_q[j_q][a_q] <= cur_neg ? -coord_t'(div_q) : coord_t'(div_q);
						state_q <= S_M_NEXT;
					end
				end
				S_M_NEXT: begin
					if (a_q != 2'd2 && cnt_q[j_q] != '0) begin
						a_q <= a_q + 2'd1;
						state_q <= S_M_START;
					end else if (j_q == CW'(NUM_CENTROIDS - 1)) begin
						state_q <= S_CHECK;
					end else begin
						a_q <= '0;
						j_q <= j_q + CW'(1);
						state_q <= S_M_START;
					end
				end
				S_CHECK: begin
					i_q <= '0;
					if (changed_q && (iter_q + 7'd1) < maxit_q) begin
						iter_q <= iter_q + 7'd1;
						changed_q <= 1'b0;
						state_q <= S_A_RD;
					end else begin
						state_q <= S_O_RD;
					end
				end
				S_O_RD: state_q <= S_O_WAIT;
				S_O_WAIT: state_q <= S_O_SHOW;
				S_O_SHOW: begin
					if (out_ch.ready) begin
						if (NW'(i_q) + NW'(1) == n_q) begin
							n_q <= '0;
							ovf_q <= 1'b0;
							i_q <= '0;
							state_q <= S_LOAD;
						end else begin
							i_q <= i_q + AW'(1);
							state_q <= S_O_RD;
						end
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end
endmodule

### rtl/core/kmgq_checker.sv
module kmgq_props (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        in_final,
	input logic        out_valid,
	input logic        out_ready,
	input logic [5:0]  out_index,
	input logic [3:0]  out_cluster,
	input logic        out_last
);
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("input taken while results pending");
	a_busy_after_final: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_final |=> !in_ready) else $error("ready after final");
	a_cluster_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_cluster < 4'd14) else $error("cluster out of range");
	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_index))
		else $error("result dropped");
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_last |=> !out_valid)
		else $error("result after last");
endmodule

bind kmeans_gesture_quantizer kmgq_props u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.in_final(in_ch.final_sample), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.out_index(out_ch.sample_index), .out_cluster(out_ch.cluster_id),
	.out_last(out_ch.last_result)
);
